// ----- hw/rtl/plac_pkg.sv -----
// Shared types, codes and helpers for the palette layer alpha compositor.
// No dependencies; used by palette_layer_alpha_compositor and its testbench.
`timescale 1ns / 1ps
`default_nettype none

package plac_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_LAYER_OPACITY  = 3'd0,
        REG_OPERATION_MODE = 3'd1,
        REG_COMPONENT_MASK = 3'd2,
        REG_LAYER_COLORS   = 3'd3,
        REG_TABLE_START    = 3'd4,
        REG_TOTAL_COLORS   = 3'd5,
        REG_LAYER_CHANNELS = 3'd6,
        REG_OUT_CHANNELS   = 3'd7
    } cfg_reg_t;

    // Compositing operations; the unused code behaves as replace
    localparam logic [1:0] MODE_BLEND   = 2'd0;
    localparam logic [1:0] MODE_ADD     = 2'd1;
    localparam logic [1:0] MODE_REPLACE = 2'd2;

    // Item kinds carried in tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam int CFG_DATA_W = 11;
    localparam int S_TDATA_W  = 112;
    localparam int PIX_W      = 32;

    // Floor division by 255 for values up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/palette_layer_alpha_compositor.sv -----
// Top level of the palette layer alpha compositor: six-stage pixel pipeline.
// Depends on plac_pkg and plac_ram (color table storage).
//
// Channel     | Direction | Handshake               | Payload
// ------------+-----------+-------------------------+------------------------------------
// s_axis      | in        | tvalid / tready         | tuser: command; tdata: see port
// m_axis      | out       | tvalid / tready         | tdata: new_pixel
// cfg         | in        | cfg_we, no back-pressure| cfg_index, cfg_data
//
// Items: one per clock while m_axis_tready holds high. A pixel item passes
// through stages 1 to 6 and shows its result on m_axis from the stage 6
// register; a write item is registered in stage 1, lands in the color table
// as it leaves that stage and makes no result. The pipeline holds the table
// read (registered RAM port), the two 8x8 multiply stages and the two divide-by-255 stages.
// Reset clears all valid bits and loads the register defaults; the color
// table is not cleared. Each stage holds its item while the next one is full
// and stalled, so bubbles collapse and nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module palette_layer_alpha_compositor #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Input items
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [9:0] table_index, [41:10] table_color, [73:42] layer_pixel,
    // [105:74] old_pixel, [111:106] zero
    input  wire logic [plac_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] command
    input  wire logic                           s_axis_tuser,
    // Result items
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [31:0] new_pixel
    output logic      [plac_pkg::PIX_W-1:0]     m_axis_tdata,
    // Configuration writes
    input  wire logic                           cfg_we,
    input  wire logic [2:0]                     cfg_index,
    input  wire logic [plac_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  layer_opacity_reg;
    logic [1:0]  operation_mode_reg;
    logic [3:0]  component_mask_reg;
    logic [8:0]  layer_colors_reg;
    logic [9:0]  table_start_reg;
    logic [10:0] total_colors_reg;
    logic [2:0]  layer_channels_reg;
    logic [2:0]  out_channels_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_opacity_reg  <= 8'd255;
            operation_mode_reg <= plac_pkg::MODE_BLEND;
            component_mask_reg <= 4'hF;
            layer_colors_reg   <= 9'd0;
            table_start_reg    <= 10'd0;
            total_colors_reg   <= 11'd0;
            layer_channels_reg <= 3'd4;
            out_channels_reg   <= 3'd4;
        end
        else if (cfg_we)
        begin
            unique case (plac_pkg::cfg_reg_t'(cfg_index))
                plac_pkg::REG_LAYER_OPACITY:  layer_opacity_reg  <= cfg_data[7:0];
                plac_pkg::REG_OPERATION_MODE: operation_mode_reg <= cfg_data[1:0];
                plac_pkg::REG_COMPONENT_MASK: component_mask_reg <= cfg_data[3:0];
                plac_pkg::REG_LAYER_COLORS:   layer_colors_reg   <= cfg_data[8:0];
                plac_pkg::REG_TABLE_START:    table_start_reg    <= cfg_data[9:0];
                plac_pkg::REG_TOTAL_COLORS:   total_colors_reg   <= cfg_data[10:0];
                plac_pkg::REG_LAYER_CHANNELS: layer_channels_reg <= cfg_data[2:0];
                plac_pkg::REG_OUT_CHANNELS:   out_channels_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and the ready chain. Each stage advances when it is
    // empty or its successor takes its item this cycle.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6 = !v6_reg || m_axis_tready;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_axis_tready = rdy1;

    // ------------------------------------------------------------------
    // Stage 1: capture the item, clamp the palette index to the layer
    // ------------------------------------------------------------------
    logic        cmd1_reg;
    logic [9:0]  tindex1_reg;
    logic [31:0] tcolor1_reg;
    logic [31:0] pix1_reg;
    logic [31:0] old1_reg;
    logic [8:0]  idx1_reg;
    logic [8:0]  idx1_next;
    logic [7:0]  in_b0;

    assign in_b0     = s_axis_tdata[49:42];
    assign idx1_next = ({1'b0, in_b0} >= layer_colors_reg) ? (layer_colors_reg - 9'd1)
                                                            : {1'b0, in_b0};

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            cmd1_reg    <= s_axis_tuser;
            tindex1_reg <= s_axis_tdata[9:0];
            tcolor1_reg <= s_axis_tdata[41:10];
            pix1_reg    <= s_axis_tdata[73:42];
            old1_reg    <= s_axis_tdata[105:74];
            idx1_reg    <= idx1_next;
        end
    end

    // ------------------------------------------------------------------
    // Table access: writes retire here; pixel items offset and clamp the
    // index and issue the read. Both happen in item order at one stage, so
    // a read always sees every earlier write.
    // ------------------------------------------------------------------
    logic          s1_move;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_rdata;
    logic [10:0]   idx_sum;
    logic [10:0]   idx_tot;
    logic [10:0]   idx_fin;

    assign s1_move = v1_reg && rdy2;

    always_comb
    begin
        idx_sum = {2'd0, idx1_reg} + {1'b0, table_start_reg};
        if (idx_sum >= total_colors_reg)
        begin
            idx_tot = (total_colors_reg == 11'd0) ? 11'd0 : (total_colors_reg - 11'd1);
        end
        else
        begin
            idx_tot = idx_sum;
        end
        // saturate at the top of the table
        if (32'(idx_tot) >= TABLE_DEPTH)
        begin
            idx_fin = 11'(TABLE_DEPTH - 1);
        end
        else
        begin
            idx_fin = idx_tot;
        end
    end

    assign ram_we    = s1_move && (cmd1_reg == plac_pkg::CMD_WRITE)
                       && (32'(tindex1_reg) < TABLE_DEPTH);
    assign ram_waddr = AW'(tindex1_reg);
    assign ram_re    = s1_move && (cmd1_reg == plac_pkg::CMD_PIXEL);
    assign ram_raddr = AW'(idx_fin);

    plac_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_color_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tcolor1_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 2: table data arrives; only pixel items stay valid from here
    // ------------------------------------------------------------------
    logic [31:0] pix2_reg;
    logic [31:0] old2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            pix2_reg <= pix1_reg;
            old2_reg <= old1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: expand to RGBA, multiply alpha by opacity
    // ------------------------------------------------------------------
    logic [31:0] src_next;
    logic [31:0] src3_reg;
    logic [15:0] prod3_reg;
    logic [31:0] old3_reg;

    always_comb
    begin
        if (layer_colors_reg != 9'd0)
        begin
            src_next = ram_rdata;
        end
        else if (layer_channels_reg == 3'd1)
        begin
            src_next = {4{pix2_reg[7:0]}};
        end
        else if (layer_channels_reg == 3'd3)
        begin
            src_next = {8'd0, pix2_reg[23:0]};
        end
        else
        begin
            src_next = pix2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            src3_reg  <= src_next;
            prod3_reg <= 16'(src_next[31:24]) * 16'(layer_opacity_reg);
            old3_reg  <= old2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scaled alpha = product / 255
    // ------------------------------------------------------------------
    logic [7:0]  alpha4_reg;
    logic [23:0] rgb4_reg;
    logic [31:0] old4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            alpha4_reg <= plac_pkg::div255(prod3_reg);
            rgb4_reg   <= src3_reg[23:0];
            old4_reg   <= old3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: blend products old*(255-a) + pix*a per color channel
    // ------------------------------------------------------------------
    logic [15:0] blend5_reg [3];
    logic [15:0] blend_next [3];
    logic [31:0] src5_reg;
    logic [31:0] old5_reg;
    logic [7:0]  trans4;

    assign trans4 = 8'd255 - alpha4_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            blend_next[c] = 16'(old4_reg[8*c +: 8]) * 16'(trans4)
                          + 16'(rgb4_reg[8*c +: 8]) * 16'(alpha4_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            for (int c = 0; c < 3; c++)
            begin
                blend5_reg[c] <= blend_next[c];
            end
            src5_reg <= {alpha4_reg, rgb4_reg};
            old5_reg <= old4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: pick the per-channel result, apply mask, output register
    // ------------------------------------------------------------------
    logic [31:0] new_next;
    logic [31:0] new6_reg;
    logic        alpha_on;

    assign alpha_on = (out_channels_reg >= 3'd4);

    always_comb
    begin
        new_next = old5_reg;
        if (layer_opacity_reg != 8'd0)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (component_mask_reg[c] && ((c < 3) || alpha_on))
                begin
                    unique case (operation_mode_reg)
                        plac_pkg::MODE_BLEND:
                        begin
                            // blend never touches alpha
                            if (c < 3)
                            begin
                                new_next[8*c +: 8] = plac_pkg::div255(blend5_reg[c % 3]);
                            end
                        end
                        plac_pkg::MODE_ADD:
                        begin
                            new_next[8*c +: 8] = 8'(({1'b0, old5_reg[8*c +: 8]}
                                                   + {1'b0, src5_reg[8*c +: 8]}) >> 1);
                        end
                        default:
                        begin
                            new_next[8*c +: 8] = src5_reg[8*c +: 8];
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            new6_reg <= new_next;
        end
    end

    assign m_axis_tvalid = v6_reg;
    assign m_axis_tdata  = new6_reg;

    // ------------------------------------------------------------------
    // Valid bits: write items drop out after the table access
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg && (cmd1_reg == plac_pkg::CMD_PIXEL);
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // One item at the table stage: never a write and a read together
    a_ram_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("color table written and read in one cycle");

    // Table data must hold while its stage is stalled
    a_ram_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !rdy3) |=> (ram_rdata === $past(ram_rdata)))
        else $error("table read data lost under stall");

    // Scaled alpha can never exceed the opacity
    a_alpha_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (alpha4_reg <= layer_opacity_reg))
        else $error("scaled alpha above layer opacity");

    // A stalled output stage holds back the input
    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && v6_reg && !m_axis_tready)
        |-> !s_axis_tready)
        else $error("input accepted with a full stalled pipeline");

endmodule

`default_nettype wire

// ----- hw/rtl/plac_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module plac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- verif/palette_layer_alpha_compositor_tb.sv -----
// Self-checking testbench for palette_layer_alpha_compositor: directed and random items.
// Depends on plac_pkg and the compositor RTL. Results are checked against an in-bench model.
`timescale 1ns / 1ps

module palette_layer_alpha_compositor_tb;

    localparam int TABLE_DEPTH     = 1024;
    localparam int NUM_PHASES      = 13;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int SETTLE_CYCLES   = 10;   // six pipeline stages plus the table write
    localparam int HOLD_OFF_CYCLES = 80;   // long enough to fill every stage
    localparam int STALL_LIMIT     = 1000; // cycles with no handshake or register write at all

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    // One line of the directed table: a register write or an item on the input stream.
    // Where known is set, want is the result read straight off the spec.
    typedef struct packed {
        row_kind_t          kind;
        plac_pkg::cfg_reg_t reg_sel;
        logic [10:0]        value;
        logic               cmd;
        logic [9:0]         idx;
        logic [31:0]        color;
        logic [31:0]        lp;
        logic [31:0]        old;
        bit                 known;
        logic [31:0]        want;
    } directed_row_t;

    typedef struct packed {
        bit          known;
        logic [31:0] want;
    } typed_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [plac_pkg::S_TDATA_W-1:0]  s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [plac_pkg::PIX_W-1:0]      m_axis_tdata;
    logic                            cfg_we;
    logic [2:0]                      cfg_index;
    logic [plac_pkg::CFG_DATA_W-1:0] cfg_data;

    // Mirror of the block's registers and color table, as the block should hold them
    logic [7:0]  cur_opacity      = 8'd255;
    logic [1:0]  cur_mode         = plac_pkg::MODE_BLEND;
    logic [3:0]  cur_mask         = 4'hF;
    logic [8:0]  cur_layer_colors = 9'd0;
    logic [9:0]  cur_table_start  = 10'd0;
    logic [10:0] cur_total_colors = 11'd0;
    logic [2:0]  cur_layer_chans  = 3'd4;
    logic [2:0]  cur_out_chans    = 3'd4;
    logic [31:0] table_mirror [TABLE_DEPTH];

    // Entries that the stimulus has written; palette reads never touch any other entry
    bit          entry_written [TABLE_DEPTH];

    logic [31:0]   pending_pixels [$];   // composited pixels still owed by the block
    typed_result_t typed_results [$];    // per sent item: a hand-typed result, if any
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    bit            sender_gaps = 1'b1;
    bit            receiver_gaps = 1'b1;
    bit            hold_off_request = 1'b0;

    palette_layer_alpha_compositor #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Model of the compositor
    // ------------------------------------------------------------------

    // Table entry a palette byte selects: clamp to the layer's colors, offset by the
    // layer's start, clamp to the table size in use, then saturate at the last entry.
    function automatic int palette_slot(input logic [7:0] index_byte);
        int slot;
        slot = int'(index_byte);
        if (slot >= int'(cur_layer_colors))
            slot = int'(cur_layer_colors) - 1;
        slot += int'(cur_table_start);
        if (slot >= int'(cur_total_colors))
            slot = (cur_total_colors == 0) ? 0 : int'(cur_total_colors) - 1;
        if (slot >= TABLE_DEPTH)
            slot = TABLE_DEPTH - 1;
        return slot;
    endfunction

    function automatic logic [31:0] composite_pixel(input logic [31:0] lp,
                                                    input logic [31:0] old);
        logic [31:0] src;
        logic [31:0] res;
        int          alpha;
        int          o;
        int          p;
        int          v;
        int          nch;
        // Fully transparent layer: destination untouched
        if (cur_opacity == 8'd0)
            return old;
        if (cur_layer_colors != 0)
            src = table_mirror[palette_slot(lp[7:0])];
        else if (cur_layer_chans == 3'd1)
            src = {4{lp[7:0]}};
        else if (cur_layer_chans == 3'd3)
            src = {8'h00, lp[23:0]};
        else
            src = lp;
        alpha = int'(src[31:24]) * int'(cur_opacity) / 255;
        src[31:24] = alpha[7:0];
        nch = (cur_out_chans >= 3'd4) ? 4 : 3;
        res = old;
        for (int c = 0; c < nch; c++)
        begin
            if (!cur_mask[c])
                continue;
            o = int'(old[8*c +: 8]);
            p = int'(src[8*c +: 8]);
            if (cur_mode == plac_pkg::MODE_BLEND)
            begin
                // blending leaves the destination alpha alone
                if (c == 3)
                    continue;
                v = (o * (255 - alpha) + p * alpha) / 255;
            end
            else if (cur_mode == plac_pkg::MODE_ADD)
                v = (o + p) >> 1;
            else
                v = p;   // replace, and the unused fourth code behaves the same
            res[8*c +: 8] = v[7:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: predict on input handshakes, check on output handshakes
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        typed_result_t hint;
        logic [31:0]   want;
        if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
        begin
            hint = '0;
            if (typed_results.size() != 0)
                hint = typed_results.pop_front();
            if (s_axis_tuser == plac_pkg::CMD_WRITE)
                table_mirror[s_axis_tdata[9:0]] = s_axis_tdata[41:10];
            else
            begin
                want = hint.known ? hint.want
                                  : composite_pixel(s_axis_tdata[73:42], s_axis_tdata[105:74]);
                pending_pixels.push_back(want);
            end
        end
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("new_pixel: expected none, got %08h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata !== want)
                begin
                    $error("new_pixel: expected %08h, got %08h", want, m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
        // Count cycles with no progress anywhere for the watchdog
        if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("palette_layer_alpha_compositor: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : receiver
        m_axis_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                // hold off long enough that the pipeline fills and stalls its input
                hold_off_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (receiver_gaps && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Sender side helpers
    // ------------------------------------------------------------------

    // Offer one item and hold it until the block takes it. Lower valid for a random
    // burst first when gaps are on.
    task automatic send_item(input logic cmd, input logic [9:0] idx, input logic [31:0] color,
                             input logic [31:0] lp, input logic [31:0] old,
                             input bit known, input logic [31:0] want);
        typed_result_t hint;
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'd0, old, lp, color, idx};
        hint.known = known;
        hint.want  = want;
        typed_results.push_back(hint);
        if (cmd == plac_pkg::CMD_WRITE)
            entry_written[idx] = 1'b1;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
    endtask

    // Drop valid, wait for every owed pixel, then let the pipeline drain of
    // trailing table writes too.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0 || typed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input plac_pkg::cfg_reg_t sel, input logic [10:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (sel)
            plac_pkg::REG_LAYER_OPACITY:  cur_opacity      = value[7:0];
            plac_pkg::REG_OPERATION_MODE: cur_mode         = value[1:0];
            plac_pkg::REG_COMPONENT_MASK: cur_mask         = value[3:0];
            plac_pkg::REG_LAYER_COLORS:   cur_layer_colors = value[8:0];
            plac_pkg::REG_TABLE_START:    cur_table_start  = value[9:0];
            plac_pkg::REG_TOTAL_COLORS:   cur_total_colors = value[10:0];
            plac_pkg::REG_LAYER_CHANNELS: cur_layer_chans  = value[2:0];
            plac_pkg::REG_OUT_CHANNELS:   cur_out_chans    = value[2:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Register setting for one phase: phase 0 holds the low corner, phase 1 every
    // field at its widest value, the rest are random with the extremes weighted in.
    function automatic logic [10:0] choose_setting(input plac_pkg::cfg_reg_t sel,
                                                   input int phase);
        logic [10:0] v;
        int          roll;
        roll = $urandom_range(0, 7);
        case (sel)
            plac_pkg::REG_LAYER_OPACITY:
                if (phase == 0)     v = 11'd1;
                else if (phase == 1 || roll == 1) v = 11'd255;
                else if (roll == 0) v = 11'd0;
                else                v = 11'($urandom_range(1, 254));
            plac_pkg::REG_OPERATION_MODE:
                if (phase == 0)      v = 11'(plac_pkg::MODE_BLEND);
                else if (phase == 1) v = 11'd3;
                else                 v = 11'($urandom_range(0, 3));
            plac_pkg::REG_COMPONENT_MASK:
                if (phase <= 1 || roll < 3) v = 11'd15;
                else                        v = 11'($urandom_range(0, 15));
            plac_pkg::REG_LAYER_COLORS:
                if (phase == 0)      v = 11'd1;
                else if (phase == 1) v = 11'd511;
                else if (roll < 3)   v = 11'd0;
                else if (roll == 3)  v = 11'd256;
                else                 v = 11'($urandom_range(1, 511));
            plac_pkg::REG_TABLE_START:
                if (phase == 0 || roll == 0)      v = 11'd0;
                else if (phase == 1 || roll == 1) v = 11'd1023;
                else                              v = 11'($urandom_range(0, 1023));
            plac_pkg::REG_TOTAL_COLORS:
                if (phase == 0)      v = 11'd1;
                else if (phase == 1) v = 11'd2047;
                else if (roll == 0)  v = 11'd0;
                else if (roll == 1)  v = 11'd1024;
                else if (roll == 2)  v = 11'($urandom_range(1025, 2047));
                else                 v = 11'($urandom_range(0, 1024));
            plac_pkg::REG_LAYER_CHANNELS:
                if (phase == 0)      v = 11'd0;
                else if (phase == 1) v = 11'd7;
                else if (roll < 2)   v = 11'd1;
                else if (roll < 4)   v = 11'd3;
                else if (roll < 6)   v = 11'd4;
                else                 v = 11'($urandom_range(0, 7));
            default:
                if (phase == 0)      v = 11'd0;
                else if (phase == 1) v = 11'd7;
                else if (roll < 3)   v = 11'd4;
                else if (roll < 5)   v = 11'd3;
                else                 v = 11'($urandom_range(0, 7));
        endcase
        return v;
    endfunction

    // Pixel words with the all-zero, all-one and opaque/clear alpha corners mixed in
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(0, 7))
            0: w = 32'h0000_0000;
            1: w = 32'hFFFF_FFFF;
            2:
            begin
                w = $urandom;
                w[31:24] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Table addresses: mostly inside the current layer's palette, some at the ends
    function automatic logic [9:0] pick_index();
        int slot;
        case ($urandom_range(0, 3))
            0: slot = $urandom_range(0, TABLE_DEPTH - 1);
            1: slot = $urandom_range(0, 1) ? TABLE_DEPTH - 1 : 0;
            default:
            begin
                slot = int'(cur_table_start) + $urandom_range(0, int'(cur_layer_colors));
                if (slot >= TABLE_DEPTH)
                    slot = TABLE_DEPTH - 1;
            end
        endcase
        return slot[9:0];
    endfunction

    // Random traffic under the current settings. A palette pixel whose entry was never
    // written gets a write to that entry just ahead of it; that write counts as an item.
    task automatic run_phase(input int n_items);
        logic [31:0] lp;
        logic [31:0] old;
        int          slot;
        for (int k = 0; k < n_items; k++)
        begin
            if ($urandom_range(0, 4) == 0)
                send_item(plac_pkg::CMD_WRITE, pick_index(), pick_word(), $urandom, $urandom,
                          1'b0, '0);
            else
            begin
                lp  = pick_word();
                old = pick_word();
                if (cur_layer_colors != 0)
                begin
                    slot = palette_slot(lp[7:0]);
                    if (!entry_written[slot])
                    begin
                        send_item(plac_pkg::CMD_WRITE, slot[9:0], pick_word(), $urandom,
                                  $urandom, 1'b0, '0);
                        k++;
                    end
                end
                send_item(plac_pkg::CMD_PIXEL, 10'($urandom), $urandom, lp, old, 1'b0, '0);
            end
        end
    endtask

    function automatic directed_row_t cfg_row(input plac_pkg::cfg_reg_t sel,
                                              input logic [10:0] value);
        directed_row_t r;
        r = '0;
        r.kind    = ROW_CFG;
        r.reg_sel = sel;
        r.value   = value;
        return r;
    endfunction

    function automatic directed_row_t write_row(input logic [9:0] idx, input logic [31:0] color);
        directed_row_t r;
        r = '0;
        r.kind  = ROW_ITEM;
        r.cmd   = plac_pkg::CMD_WRITE;
        r.idx   = idx;
        r.color = color;
        return r;
    endfunction

    function automatic directed_row_t pixel_row(input logic [31:0] lp, input logic [31:0] old,
                                                input bit known, input logic [31:0] want);
        directed_row_t r;
        r = '0;
        r.kind  = ROW_ITEM;
        r.cmd   = plac_pkg::CMD_PIXEL;
        r.lp    = lp;
        r.old   = old;
        r.known = known;
        r.want  = want;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        directed_row_t directed_rows [$];

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= plac_pkg::CMD_WRITE;
        cfg_we        <= 1'b0;
        cfg_index     <= plac_pkg::REG_LAYER_OPACITY;
        cfg_data      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: full opacity, blend, all channels, direct RGBA
        directed_rows.push_back(pixel_row(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h00FF_FFFF));
        directed_rows.push_back(pixel_row(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
        directed_rows.push_back(pixel_row(32'h80C0_4020, 32'h1020_3040, 1'b0, '0));
        // Zero opacity skips the layer
        directed_rows.push_back(cfg_row(plac_pkg::REG_LAYER_OPACITY, 11'd0));
        directed_rows.push_back(pixel_row(32'h1234_5678, 32'h89AB_CDEF, 1'b1, 32'h89AB_CDEF));
        directed_rows.push_back(cfg_row(plac_pkg::REG_LAYER_OPACITY, 11'd255));
        // Add averages every channel, alpha included
        directed_rows.push_back(cfg_row(plac_pkg::REG_OPERATION_MODE, 11'(plac_pkg::MODE_ADD)));
        directed_rows.push_back(pixel_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
        directed_rows.push_back(pixel_row(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h7F7F_7F7F));
        directed_rows.push_back(cfg_row(plac_pkg::REG_OPERATION_MODE,
                                        11'(plac_pkg::MODE_REPLACE)));
        directed_rows.push_back(pixel_row(32'hA1B2_C3D4, 32'h0000_0000, 1'b1, 32'hA1B2_C3D4));
        // The spare mode code acts as replace
        directed_rows.push_back(cfg_row(plac_pkg::REG_OPERATION_MODE, 11'd3));
        directed_rows.push_back(pixel_row(32'hA1B2_C3D4, 32'hFFFF_FFFF, 1'b1, 32'hA1B2_C3D4));
        // Masked-off channels pass through from the destination
        directed_rows.push_back(cfg_row(plac_pkg::REG_COMPONENT_MASK, 11'd0));
        directed_rows.push_back(pixel_row(32'hA1B2_C3D4, 32'h5A5A_5A5A, 1'b1, 32'h5A5A_5A5A));
        directed_rows.push_back(cfg_row(plac_pkg::REG_COMPONENT_MASK, 11'd5));
        directed_rows.push_back(pixel_row(32'h1122_3344, 32'hAABB_CCDD, 1'b1, 32'hAA22_CC44));
        directed_rows.push_back(cfg_row(plac_pkg::REG_COMPONENT_MASK, 11'd15));
        // Three output channels keep the destination alpha byte
        directed_rows.push_back(cfg_row(plac_pkg::REG_OUT_CHANNELS, 11'd3));
        directed_rows.push_back(pixel_row(32'h1122_3344, 32'hAABB_CCDD, 1'b1, 32'hAA22_3344));
        directed_rows.push_back(cfg_row(plac_pkg::REG_OUT_CHANNELS, 11'd7));
        directed_rows.push_back(pixel_row(32'h1122_3344, 32'hAABB_CCDD, 1'b1, 32'h1122_3344));
        // Gray fans byte 0 out, RGB forces alpha to zero, any other count is RGBA
        directed_rows.push_back(cfg_row(plac_pkg::REG_LAYER_CHANNELS, 11'd1));
        directed_rows.push_back(pixel_row(32'h0000_005A, 32'h0000_0000, 1'b1, 32'h5A5A_5A5A));
        directed_rows.push_back(cfg_row(plac_pkg::REG_LAYER_CHANNELS, 11'd3));
        directed_rows.push_back(pixel_row(32'h80FF_FFFF, 32'h1234_5678, 1'b1, 32'h00FF_FFFF));
        directed_rows.push_back(cfg_row(plac_pkg::REG_LAYER_CHANNELS, 11'd0));
        directed_rows.push_back(pixel_row(32'h8040_2010, 32'h0000_0000, 1'b1, 32'h8040_2010));
        // Load the table ends and a couple of entries for the palette cases
        directed_rows.push_back(write_row(10'd0, 32'h1122_3344));
        directed_rows.push_back(write_row(10'd1023, 32'hDEAD_BEEF));
        directed_rows.push_back(write_row(10'd512, 32'h0000_0000));
        directed_rows.push_back(write_row(10'd1, 32'hFFFF_FFFF));
        // Palette with zero total colors reads entry 0
        directed_rows.push_back(cfg_row(plac_pkg::REG_LAYER_COLORS, 11'd256));
        directed_rows.push_back(pixel_row(32'h0000_00FF, 32'h0000_0000, 1'b1, 32'h1122_3344));
        // Index past the table saturates at the last entry
        directed_rows.push_back(cfg_row(plac_pkg::REG_TOTAL_COLORS, 11'd2047));
        directed_rows.push_back(cfg_row(plac_pkg::REG_TABLE_START, 11'd1023));
        directed_rows.push_back(pixel_row(32'h0000_00FF, 32'h0000_0000, 1'b1, 32'hDEAD_BEEF));
        directed_rows.push_back(cfg_row(plac_pkg::REG_LAYER_COLORS, 11'd511));
        directed_rows.push_back(cfg_row(plac_pkg::REG_TABLE_START, 11'd0));
        directed_rows.push_back(pixel_row(32'h0000_0001, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF));
        // Half opacity blend through the palette
        directed_rows.push_back(cfg_row(plac_pkg::REG_OPERATION_MODE,
                                        11'(plac_pkg::MODE_BLEND)));
        directed_rows.push_back(cfg_row(plac_pkg::REG_LAYER_OPACITY, 11'd128));
        directed_rows.push_back(pixel_row(32'h0000_0001, 32'h4080_C0FF, 1'b0, '0));
        directed_rows.push_back(pixel_row(32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b0, '0));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                settle();
                cfg_write(directed_rows[i].reg_sel, directed_rows[i].value);
            end
            else
                send_item(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].color,
                          directed_rows[i].lp, directed_rows[i].old,
                          directed_rows[i].known, directed_rows[i].want);
        end

        // Random phases: rewrite every register, then stream mixed items.
        // Phase 3 carries the long receiver hold-off; the last two run without gaps.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            for (int r = 0; r < 8; r++)
                cfg_write(plac_pkg::cfg_reg_t'(r),
                          choose_setting(plac_pkg::cfg_reg_t'(r), phase));
            if (phase == 3)
                hold_off_request = 1'b1;
            if (phase >= NUM_PHASES - 2)
            begin
                sender_gaps   = 1'b0;
                receiver_gaps = 1'b0;
            end
            run_phase(ITEMS_PER_PHASE);
        end

        settle();
        if (mismatch_count == 0)
            $display("palette_layer_alpha_compositor: match");
        else
            $display("palette_layer_alpha_compositor: mismatch");
        $finish;
    end

endmodule
